// File: hw/rtl/assert_macros.svh
// Assertion macros used by the compositor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

// Implication checked in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/ibpc_pkg.sv
// ----------------------------------------------------------------------------
// ibpc_pkg
// Types, constants and helpers of the border pad compositor.
// ----------------------------------------------------------------------------
package ibpc_pkg;

	localparam int IBPC_MAX_DIM  = 4096;
	localparam int IBPC_CHANNELS = 4;
	localparam int RAD_W  = 42;
	localparam int ROOT_W = RAD_W / 2;
	localparam int FRAC_W = 16;

	// Register indexes.
	localparam logic [2:0] REG_SRC_W   = 3'd0;
	localparam logic [2:0] REG_SRC_H   = 3'd1;
	localparam logic [2:0] REG_PAD_L   = 3'd2;
	localparam logic [2:0] REG_PAD_T   = 3'd3;
	localparam logic [2:0] REG_OUT_W   = 3'd4;
	localparam logic [2:0] REG_OUT_H   = 3'd5;
	localparam logic [2:0] REG_FILL    = 3'd6;
	localparam logic [2:0] REG_MODE    = 3'd7;

	typedef struct packed {
		logic [7:0] src_c3;
		logic [7:0] src_c2;
		logic [7:0] src_c1;
		logic [7:0] src_c0;
	} in_word_t;

	typedef struct packed {
		logic       setup_error;
		logic       frame_last;
		logic       took_source;
		logic [7:0] out_c3;
		logic [7:0] out_c2;
		logic [7:0] out_c1;
		logic [7:0] out_c0;
	} out_word_t;

	// Clamp a dimension register to 1 .. IBPC_MAX_DIM.
	function automatic logic [12:0] clamp_dim(input logic [12:0] v);
		logic [12:0] r;
		if (v == 13'd0) r = 13'd1;
		else if (v > 13'(IBPC_MAX_DIM)) r = 13'(IBPC_MAX_DIM);
		else r = v;
		return r;
	endfunction

endpackage

// File: hw/rtl/image_border_pad_compositor.sv
// ----------------------------------------------------------------------------
// image_border_pad_compositor
// Writes an output raster with a source window, solid or gradient border.
// ----------------------------------------------------------------------------
// Usage: each accepted input word is the next offered source pixel and makes
// exactly one output word, scanning columns then rows. took_source tells the
// sender whether the offered pixel was consumed or must be offered again.
// Both channels use valid and stall; configuration is written through cfg_we,
// cfg_index and cfg_data, which the user must do only while the block is idle;
// the block itself does not enforce this.
// Timing: a pixel inside the window or with a solid border is in the output
// register the cycle after acceptance. A gradient pixel starts the two
// parallel square roots, which give one root bit per cycle, then starts the
// divider, waits for its quotient, blends the lanes and loads the output. When
// the factor saturates the divider finishes at once.
// One word is worked on at a time, so a new word is taken once the previous
// result is in the output register and that register is free.
// Reset sets the counters, control state, output valid and configuration to
// their defaults. A stalled output word holds; input stays stalled until it goes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module image_border_pad_compositor import ibpc_pkg::*; #(
	parameter int CHANNELS = IBPC_CHANNELS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data,
	input  logic      cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SQ    = 3'd1;
	localparam logic [2:0] S_ROOT  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_BLEND = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [12:0] src_w_q, src_h_q, out_w_q, out_h_q;
	logic [11:0] pad_l_q, pad_t_q;
	logic [31:0] fill_q;
	logic        mode_q;
	logic [11:0] col_q, row_q;
	logic [2:0]  state_q;
	logic        out_valid_q;
	out_word_t   out_q;
	logic [11:0] x_q, y_q;
	logic [12:0] ow_q, oh_q;
	logic        last_q;

	logic [12:0] sw, sh, ow, oh;
	logic        err, in_win, take, last, grad, accept, out_free, out_load;
	logic [12:0] x_inc, y_inc;
	logic [13:0] win_r, win_b;
	logic [3:0][7:0] pix, blend_v;
	logic [RAD_W-1:0]  rad_d, rad_dd;
	logic [ROOT_W-1:0] root_d, root_dd;
	logic        sq_done, sq_done_dd, div_done;
	logic [FRAC_W:0] f;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 13'd1; src_h_q <= 13'd1;
			pad_l_q <= '0;    pad_t_q <= '0;
			out_w_q <= 13'd1; out_h_q <= 13'd1;
			fill_q  <= '0;    mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_W: src_w_q <= cfg_data[12:0];
				REG_SRC_H: src_h_q <= cfg_data[12:0];
				REG_PAD_L: pad_l_q <= cfg_data[11:0];
				REG_PAD_T: pad_t_q <= cfg_data[11:0];
				REG_OUT_W: out_w_q <= cfg_data[12:0];
				REG_OUT_H: out_h_q <= cfg_data[12:0];
				REG_FILL:  fill_q  <= cfg_data;
				REG_MODE:  mode_q  <= cfg_data[0];
				default:   mode_q  <= mode_q;
			endcase
		end
	end

	// Window decode from the counters.
	assign sw = clamp_dim(src_w_q);
	assign sh = clamp_dim(src_h_q);
	assign ow = clamp_dim(out_w_q);
	assign oh = clamp_dim(out_h_q);
	assign win_r  = 14'(pad_l_q) + 14'(sw);
	assign win_b  = 14'(pad_t_q) + 14'(sh);
	assign err    = (win_r > 14'(ow)) || (win_b > 14'(oh));
	assign in_win = (col_q >= pad_l_q) && (14'(col_q) < win_r) &&
		(row_q >= pad_t_q) && (14'(row_q) < win_b);
	assign take   = !err && in_win;
	assign grad   = !err && !take && mode_q;
	assign x_inc  = 13'(col_q) + 13'd1;
	assign y_inc  = 13'(row_q) + 13'd1;
	assign last   = (x_inc >= ow) && (y_inc >= oh);

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && !in_stall;
	assign in_stall = !((state_q == S_IDLE) && out_free);

	// The output register is loaded by a direct pixel or a finished gradient.
	assign out_load = ((state_q == S_IDLE) && accept && !grad) ||
		((state_q == S_DONE) && out_free);

	// Direct pixel: source or fill colour per channel.
	assign pix[0] = take ? in_data.src_c0 : fill_q[7:0];
	assign pix[1] = take ? in_data.src_c1 : fill_q[15:8];
	assign pix[2] = take ? in_data.src_c2 : fill_q[23:16];
	assign pix[3] = take ? in_data.src_c3 : fill_q[31:24];

	// Squared distances feed both square roots together.
	assign rad_d  = {1'b0, 25'(25'(x_q) * 25'(x_q) + 25'(y_q) * 25'(y_q)), 16'b0};
	assign rad_dd = {26'(26'(ow_q) * 26'(ow_q) + 26'(oh_q) * 26'(oh_q)), 16'b0};

	ibpc_sqrt u_sqrt_d (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_SQ),
		.radicand(rad_d), .done(sq_done), .root(root_d)
	);

	ibpc_sqrt u_sqrt_dd (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_SQ),
		.radicand(rad_dd), .done(sq_done_dd), .root(root_dd)
	);

	ibpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start((state_q == S_ROOT) && sq_done),
		.num(root_d), .den(root_dd), .done(div_done), .quot(f)
	);

	// Blend lanes, one per channel in use.
	for (genvar c = 0; c < 4; c++) begin : g_lane
		if (c < CHANNELS) begin : g_on
			ibpc_lane u_lane (
				.clk(clk), .en(state_q == S_BLEND), .fc(fill_q[8*c +: 8]),
				.f(f), .v(blend_v[c])
			);
		end else begin : g_off
			assign blend_v[c] = 8'd0;
		end
	end

	// Sequencer, counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (x_inc >= ow) begin
							col_q <= '0;
							row_q <= (y_inc >= oh) ? 12'd0 : y_inc[11:0];
						end else begin
							col_q <= x_inc[11:0];
						end
						if (grad) state_q <= S_SQ;
					end
				end
				S_SQ:    state_q <= S_ROOT;
				S_ROOT:  if (sq_done) state_q <= S_DIV;
				S_DIV:   if (div_done) state_q <= S_BLEND;
				S_BLEND: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && accept) begin
			x_q    <= col_q;
			y_q    <= row_q;
			ow_q   <= ow;
			oh_q   <= oh;
			last_q <= last;
			out_q.out_c0      <= (0 < CHANNELS) ? pix[0] : 8'd0;
			out_q.out_c1      <= (1 < CHANNELS) ? pix[1] : 8'd0;
			out_q.out_c2      <= (2 < CHANNELS) ? pix[2] : 8'd0;
			out_q.out_c3      <= (3 < CHANNELS) ? pix[3] : 8'd0;
			out_q.took_source <= take;
			out_q.frame_last  <= last;
			out_q.setup_error <= err;
		end else if ((state_q == S_DONE) && out_free) begin
			out_q.out_c0      <= blend_v[0];
			out_q.out_c1      <= blend_v[1];
			out_q.out_c2      <= blend_v[2];
			out_q.out_c3      <= blend_v[3];
			out_q.took_source <= 1'b0;
			out_q.frame_last  <= last_q;
			out_q.setup_error <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A consumed pixel never comes with a setup error.
	`ASSERT_SAME(a_take_no_err, clk, arst_n, out_valid_q, !(out_q.took_source && out_q.setup_error))
	// Input is held off while a gradient word is in flight.
	`ASSERT_SAME(a_busy_stall, clk, arst_n, state_q != S_IDLE, in_stall)
	// Both roots finish together.
	`ASSERT_SAME(a_roots_align, clk, arst_n, sq_done, sq_done_dd)
	// A finished divide always moves on to the blend.
	`ASSERT_NEXT(a_div_blend, clk, arst_n, (state_q == S_DIV) && div_done, state_q == S_BLEND)
endmodule

// File: hw/rtl/ibpc_sqrt.sv
// ----------------------------------------------------------------------------
// ibpc_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ibpc_sqrt import ibpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+1:0] raw;
	logic [ROOT_W+1:0] trial;

	// Bring down two radicand bits and try the next root bit.
	assign raw   = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (raw >= trial) begin
				rem_q  <= raw - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= raw;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// File: hw/rtl/ibpc_div.sv
// ----------------------------------------------------------------------------
// ibpc_div
// Restoring divider giving the Q1.16 gradient factor, saturated at one.
// ----------------------------------------------------------------------------
module ibpc_div import ibpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ROOT_W-1:0] num,
	input  logic [ROOT_W-1:0] den,
	output logic              done,
	output logic [FRAC_W:0]   quot
);
	localparam int CNT_W = $clog2(FRAC_W + 1);

	logic [ROOT_W:0]   rem_q;
	logic [FRAC_W:0]   quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W:0]   shifted;

	assign shifted = {rem_q[ROOT_W-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// A numerator not below the divisor saturates at once.
				if (num >= den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(FRAC_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			quot_q <= (num >= den) ? {1'b1, {FRAC_W{1'b0}}} : '0;
		end else if (busy_q) begin
			if (shifted >= {1'b0, den}) begin
				rem_q  <= shifted - {1'b0, den};
				quot_q <= {quot_q[FRAC_W-1:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				quot_q <= {quot_q[FRAC_W-1:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// File: hw/rtl/ibpc_lane.sv
// ----------------------------------------------------------------------------
// ibpc_lane
// One channel of the gradient blend between fill colour and white.
// ----------------------------------------------------------------------------
module ibpc_lane import ibpc_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [7:0]      fc,
	input  logic [FRAC_W:0] f,
	output logic [7:0]      v
);
	logic [25:0] blend;
	logic [7:0]  v_s1;

	// (fc * (1 - f) + 255 * f + one half) scaled back by 2^16.
	assign blend = 26'(fc) * 26'((FRAC_W+1)'(1 << FRAC_W) - f)
		+ 26'(255) * 26'(f) + 26'(1 << (FRAC_W - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= blend[FRAC_W +: 8];
		end
	end

	assign v = v_s1;
endmodule
